>>> rtl/mpg_pkg.sv
package mpg_pkg;

  localparam int DM_W  = 32;
  localparam int R2_W  = 66;
  localparam int R_W   = 33;
  localparam int R3_W  = 99;
  localparam int Q_W   = 32;
  localparam int LANES = 8;

  typedef struct packed {
    logic [31:0]      mass_first;
    logic [31:0]      mass_second;
    logic [2:0][63:0] prod_first;
    logic [2:0][63:0] prod_second;
    logic [2:0]       dneg;
    logic [2:0]       dpos;
  } side_t;

  typedef struct packed {
    logic       coin;
    logic [2:0] dneg;
    logic [2:0] dpos;
  } dside_t;

endpackage

>>> rtl/mpg_isqrt.sv
module mpg_isqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [mpg_pkg::R2_W-1:0]  rad,
  input  mpg_pkg::side_t            in_side,
  output logic                      out_valid,
  output logic [mpg_pkg::R_W-1:0]   root,
  output mpg_pkg::side_t            out_side
);

  localparam int SW = mpg_pkg::R2_W + 1;
  localparam int NS = mpg_pkg::R_W;

  logic [mpg_pkg::R2_W-1:0] rem   [1:NS];
  logic [mpg_pkg::R_W-1:0]  res   [1:NS];
  mpg_pkg::side_t           side  [1:NS];
  logic                     vld   [1:NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int B = NS - 1 - k;
    logic [mpg_pkg::R2_W-1:0] rem_s;
    logic [mpg_pkg::R_W-1:0]  res_s;
    mpg_pkg::side_t           side_s;
    logic                     vld_s;
    logic [SW-1:0]            trial;
    logic                     ge;

    if (k == 0) begin : g_first
      assign rem_s  = rad;
      assign res_s  = '0;
      assign side_s = in_side;
      assign vld_s  = in_valid;
    end else begin : g_next
      assign rem_s  = rem[k];
      assign res_s  = res[k];
      assign side_s = side[k];
      assign vld_s  = vld[k];
    end

    assign trial = (SW'(res_s) << (B + 1)) | (SW'(1) << (2 * B));
    assign ge    = SW'(rem_s) >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? mpg_pkg::R2_W'(SW'(rem_s) - trial) : rem_s;
        res[k+1]  <= res_s | (ge ? (mpg_pkg::R_W'(1) << B) : '0);
        side[k+1] <= side_s;
      end
    end
  end

  assign out_valid = vld[NS];
  assign root      = res[NS];
  assign out_side  = side[NS];

endmodule

>>> rtl/mpg_divider.sv
module mpg_divider #(
  parameter int NUM_W = 96
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             en,
  input  logic                                             in_valid,
  input  logic [mpg_pkg::LANES-1:0][NUM_W-1:0]             num,
  input  logic [mpg_pkg::LANES-1:0][mpg_pkg::R3_W-1:0]     den,
  input  mpg_pkg::dside_t                                  in_side,
  output logic                                             out_valid,
  output logic [mpg_pkg::LANES-1:0][mpg_pkg::Q_W-1:0]      quo,
  output logic [mpg_pkg::LANES-1:0]                        sat,
  output mpg_pkg::dside_t                                  out_side
);

  localparam int CW = mpg_pkg::R3_W + mpg_pkg::Q_W;
  localparam int NS = mpg_pkg::Q_W;

  logic                                          vld   [0:NS];
  mpg_pkg::dside_t                               sd    [0:NS];
  logic [mpg_pkg::LANES-1:0][NUM_W-1:0]          rem   [0:NS];
  logic [mpg_pkg::LANES-1:0][mpg_pkg::R3_W-1:0]  dr    [0:NS];
  logic [mpg_pkg::LANES-1:0][mpg_pkg::Q_W-1:0]   q     [0:NS];
  logic [mpg_pkg::LANES-1:0]                     sr    [0:NS];
  logic [mpg_pkg::LANES-1:0]                     sat_c;

  // A quotient of 2^32 or more only ever saturates, so it is flagged up front.
  always_comb begin
    for (int l = 0; l < mpg_pkg::LANES; l++) begin
      sat_c[l] = CW'(num[l]) >= {den[l], {mpg_pkg::Q_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0]  <= in_side;
      rem[0] <= num;
      dr[0]  <= den;
      q[0]   <= '0;
      sr[0]  <= sat_c;
    end
  end

  for (genvar s = 1; s <= NS; s++) begin : g_stage
    localparam int I = NS - s;
    logic [mpg_pkg::LANES-1:0][CW-1:0]          trial;
    logic [mpg_pkg::LANES-1:0]                  ge;
    logic [mpg_pkg::LANES-1:0][NUM_W-1:0]       rem_n;
    logic [mpg_pkg::LANES-1:0][mpg_pkg::Q_W-1:0] q_n;

    always_comb begin
      for (int l = 0; l < mpg_pkg::LANES; l++) begin
        trial[l] = CW'(dr[s-1][l]) << I;
        ge[l]    = CW'(rem[s-1][l]) >= trial[l];
        rem_n[l] = ge[l] ? NUM_W'(CW'(rem[s-1][l]) - trial[l]) : rem[s-1][l];
        q_n[l]   = q[s-1][l] | (ge[l] ? (mpg_pkg::Q_W'(1) << I) : '0);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vld[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[s]  <= sd[s-1];
        rem[s] <= rem_n;
        dr[s]  <= dr[s-1];
        q[s]   <= q_n;
        sr[s]  <= sr[s-1];
      end
    end
  end

  assign out_valid = vld[NS];
  assign quo       = q[NS];
  assign sat       = sr[NS];
  assign out_side  = sd[NS];

endmodule

>>> rtl/monopole_pair_gravity.sv
// Each accepted input item yields its result item on the output register.
// Throughput: one item per cycle; the pipeline only halts while a result waits on m_tready.
// The depth is set by the integer square root (33 stages) and the 32-stage divider bank.
// Reset (rst, synchronous, active high) clears all valid bits and sets full_mode to 1.
module monopole_pair_gravity #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wen,
  input  logic [0:0]   cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, first_mass, second_mass
  input  logic [255:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // potential_first, potential_second, force_first_x/y/z, force_second_x/y/z
  output logic [255:0] m_tdata,
  // coincident
  output logic [0:0]   m_tuser
);

  localparam int NUM_W = 64 + 2 * FRAC_BITS;

  logic en;
  logic full_mode;

  logic [2:0][32:0] diff;
  logic             a_valid;
  logic [2:0][31:0] a_dm;
  logic [2:0]       a_dneg;
  logic [2:0]       a_dpos;
  logic [31:0]      a_m0;
  logic [31:0]      a_m1;

  logic             b_valid;
  logic [2:0][63:0] b_sq;
  mpg_pkg::side_t   b_side;

  logic                     c_valid;
  logic [mpg_pkg::R2_W-1:0] c_r2;
  mpg_pkg::side_t           c_side;

  logic                    d_valid;
  logic [mpg_pkg::R_W-1:0] d_r;
  mpg_pkg::side_t          d_side;

  logic                     e_valid;
  logic [mpg_pkg::R2_W-1:0] e_rr;
  logic [mpg_pkg::R_W-1:0]  e_r;
  mpg_pkg::side_t           e_side;

  logic                     f_valid;
  logic [mpg_pkg::R2_W-1:0] f_plo;
  logic [mpg_pkg::R2_W-1:0] f_phi;
  logic [mpg_pkg::R_W-1:0]  f_r;
  mpg_pkg::side_t           f_side;

  logic                     g_valid;
  logic [mpg_pkg::R3_W-1:0] g_r3;
  logic [mpg_pkg::R_W-1:0]  g_r;
  mpg_pkg::side_t           g_side;

  logic [mpg_pkg::LANES-1:0][NUM_W-1:0]         dv_num;
  logic [mpg_pkg::LANES-1:0][mpg_pkg::R3_W-1:0] dv_den;
  mpg_pkg::dside_t                              dv_side;

  logic                                        q_valid;
  logic [mpg_pkg::LANES-1:0][mpg_pkg::Q_W-1:0] q_quo;
  logic [mpg_pkg::LANES-1:0]                   q_sat;
  mpg_pkg::dside_t                             q_side;

  logic [7:0][31:0] res;

  function automatic logic [31:0] sat32(input logic [31:0] q, input logic big,
                                        input logic neg);
    logic [31:0] mag;
    if (neg) begin
      mag = (big || q > 32'h8000_0000) ? 32'h8000_0000 : q;
      return 32'(-mag);
    end
    mag = (big || q[31]) ? 32'h7FFF_FFFF : q;
    return mag;
  endfunction

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_mode <= 1'b1;
    end else if (cfg_wen) begin
      full_mode <= cfg_wdata[0];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = {s_tdata[32*k+31], s_tdata[32*k +: 32]}
              - {s_tdata[32*(k+3)+31], s_tdata[32*(k+3) +: 32]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      e_valid <= 1'b0;
      f_valid <= 1'b0;
      g_valid <= 1'b0;
    end else if (en) begin
      a_valid <= s_tvalid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      e_valid <= d_valid;
      f_valid <= e_valid;
      g_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        a_dm[k]   <= diff[k][32] ? 32'(-diff[k]) : diff[k][31:0];
        a_dneg[k] <= diff[k][32];
        a_dpos[k] <= !diff[k][32] && (diff[k] != '0);
        b_sq[k]   <= 64'(a_dm[k]) * 64'(a_dm[k]);
        b_side.prod_first[k]  <= 64'(a_m0) * 64'(a_dm[k]);
        b_side.prod_second[k] <= 64'(a_m1) * 64'(a_dm[k]);
      end
      a_m0               <= s_tdata[223:192];
      a_m1               <= s_tdata[255:224];
      b_side.mass_first  <= a_m0;
      b_side.mass_second <= a_m1;
      b_side.dneg        <= a_dneg;
      b_side.dpos        <= a_dpos;

      c_r2   <= mpg_pkg::R2_W'(b_sq[0]) + mpg_pkg::R2_W'(b_sq[1])
              + mpg_pkg::R2_W'(b_sq[2]);
      c_side <= b_side;

      e_rr   <= mpg_pkg::R2_W'(d_r) * mpg_pkg::R2_W'(d_r);
      e_r    <= d_r;
      e_side <= d_side;

      f_plo  <= mpg_pkg::R2_W'(e_rr[32:0]) * mpg_pkg::R2_W'(e_r);
      f_phi  <= mpg_pkg::R2_W'(e_rr[65:33]) * mpg_pkg::R2_W'(e_r);
      f_r    <= e_r;
      f_side <= e_side;

      g_r3   <= {f_phi, 33'b0} + mpg_pkg::R3_W'(f_plo);
      g_r    <= f_r;
      g_side <= f_side;
    end
  end

  mpg_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c_valid),
    .rad       (c_r2),
    .in_side   (c_side),
    .out_valid (d_valid),
    .root      (d_r),
    .out_side  (d_side)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dv_num[k]   = NUM_W'(g_side.prod_second[k]) << (2 * FRAC_BITS);
      dv_num[k+3] = NUM_W'(g_side.prod_first[k]) << (2 * FRAC_BITS);
      dv_den[k]   = g_r3;
      dv_den[k+3] = g_r3;
    end
    dv_num[6]    = NUM_W'(g_side.mass_second) << FRAC_BITS;
    dv_num[7]    = NUM_W'(g_side.mass_first) << FRAC_BITS;
    dv_den[6]    = mpg_pkg::R3_W'(g_r);
    dv_den[7]    = mpg_pkg::R3_W'(g_r);
    dv_side.coin = (g_r == '0);
    dv_side.dneg = g_side.dneg;
    dv_side.dpos = g_side.dpos;
  end

  mpg_divider #(
    .NUM_W (NUM_W)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (g_valid),
    .num       (dv_num),
    .den       (dv_den),
    .in_side   (dv_side),
    .out_valid (q_valid),
    .quo       (q_quo),
    .sat       (q_sat),
    .out_side  (q_side)
  );

  always_comb begin
    res[0] = sat32(q_quo[6], q_sat[6], 1'b1);
    res[1] = sat32(q_quo[7], q_sat[7], 1'b1);
    for (int k = 0; k < 3; k++) begin
      res[2+k] = full_mode ? sat32(q_quo[k], q_sat[k], q_side.dneg[k]) : '0;
      res[5+k] = full_mode ? sat32(q_quo[k+3], q_sat[k+3], q_side.dpos[k]) : '0;
    end
    if (q_side.coin) begin
      res = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata    <= res;
      m_tuser[0] <= q_side.coin;
    end
  end

endmodule
